### hdl/fbpa_pkg.sv
// types, request and status codes, and register constants for the block pool allocator
// no dependencies
`default_nettype none

package fbpa_pkg;

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_REJECTED = 2'd2;

  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_OBJECT_SIZE = 1'b1;

  localparam logic [8:0]  BLOCK_COUNT_RESET = 9'd256;
  localparam logic [16:0] OBJECT_SIZE_RESET = 17'd16;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] block_index;
  } fbpa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_index;
    logic [24:0] used_total;
    logic [8:0]  live_total;
  } fbpa_rsp_t;

  typedef struct packed {
    logic [8:0]  block_count;
    logic [16:0] object_size;
  } fbpa_cfg_t;

endpackage

`default_nettype wire

### hdl/fbpa_link_ram.sv
// link memory of the free list: one write port, one registered read port
// no dependencies
`default_nettype none

module fbpa_link_ram #(
  parameter int DEPTH = 256,
  parameter int DW    = 9
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/fbpa_ctrl.sv
// request sequencer: free head, counters, init walk and link memory access
// depends on fbpa_pkg
`default_nettype none

module fbpa_ctrl #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fbpa_pkg::fbpa_cfg_t           cfg,
  input  wire logic                          start,
  input  wire fbpa_pkg::fbpa_req_t           req,
  output logic                               busy,
  output logic                               done,
  output fbpa_pkg::fbpa_rsp_t                rsp,
  output logic                               mem_we,
  output logic [$clog2(MAX_BLOCKS)-1:0]      mem_waddr,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]    mem_wdata,
  output logic [$clog2(MAX_BLOCKS)-1:0]      mem_raddr,
  input  wire logic [$clog2(MAX_BLOCKS+1)-1:0] mem_rdata
);
  import fbpa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = (LW > 9) ? LW : 9;
  localparam logic [LW-1:0] NULL_MARK = LW'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ALLOC = 3'b010,
    ST_INIT  = 3'b100
  } state_t;

  state_t        state;
  logic [LW-1:0] free_head;
  logic [24:0]   used_bytes;
  logic [8:0]    live_count;
  logic [LW-1:0] linked;
  logic [LW-1:0] init_ptr;
  logic [LW-1:0] init_n;
  logic [7:0]    granted;

  logic [CW-1:0] bc_ext;
  logic [CW-1:0] n_ext;
  logic [LW-1:0] n_blocks;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] head_ext;
  logic [LW-1:0] idx_link;
  logic          accept;
  logic          free_ok;
  logic          head_valid;
  logic [LW-1:0] init_ptr_inc;
  logic          init_last;

  always_comb begin
    bc_ext       = CW'(cfg.block_count);
    n_ext        = (bc_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : bc_ext;
    n_blocks     = n_ext[LW-1:0];
    idx_ext      = CW'(req.block_index);
    idx_link     = idx_ext[LW-1:0];
    head_ext     = CW'(free_head);
    accept       = start && (state == ST_IDLE);
    free_ok      = (idx_ext < CW'(linked)) && (live_count != 9'd0);
    head_valid   = free_head < NULL_MARK;
    init_ptr_inc = init_ptr + LW'(1);
    init_last    = init_ptr_inc == init_n;
  end

  assign busy      = state != ST_IDLE;
  assign mem_raddr = free_head[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_link[AW-1:0];
    mem_wdata = free_head;
    if (state == ST_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = init_ptr[AW-1:0];
      mem_wdata = init_last ? NULL_MARK : init_ptr_inc;
    end else if (accept && req.req_type == REQ_FREE && free_ok) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      free_head  <= NULL_MARK;
      used_bytes <= '0;
      live_count <= '0;
      linked     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rsp.status        <= STAT_OK;
            rsp.granted_index <= '0;
            rsp.used_total    <= used_bytes;
            rsp.live_total    <= live_count;
            case (req.req_type)
              REQ_INIT: begin
                if (n_blocks == '0) begin
                  free_head       <= NULL_MARK;
                  linked          <= '0;
                  used_bytes      <= '0;
                  live_count      <= '0;
                  rsp.used_total  <= '0;
                  rsp.live_total  <= '0;
                  done            <= 1'b1;
                end else begin
                  init_ptr <= '0;
                  init_n   <= n_blocks;
                  state    <= ST_INIT;
                end
              end
              REQ_ALLOC: begin
                if (head_valid) begin
                  granted <= head_ext[7:0];
                  state   <= ST_ALLOC;
                end else begin
                  rsp.status <= STAT_EMPTY;
                  done       <= 1'b1;
                end
              end
              REQ_FREE: begin
                if (free_ok) begin
                  free_head      <= idx_link;
                  used_bytes     <= used_bytes - 25'(cfg.object_size);
                  live_count     <= live_count - 9'd1;
                  rsp.used_total <= used_bytes - 25'(cfg.object_size);
                  rsp.live_total <= live_count - 9'd1;
                end else begin
                  rsp.status <= STAT_REJECTED;
                end
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_ALLOC: begin
          free_head         <= mem_rdata;
          used_bytes        <= used_bytes + 25'(cfg.object_size);
          live_count        <= live_count + 9'd1;
          rsp.status        <= STAT_OK;
          rsp.granted_index <= granted;
          rsp.used_total    <= used_bytes + 25'(cfg.object_size);
          rsp.live_total    <= live_count + 9'd1;
          done              <= 1'b1;
          state             <= ST_IDLE;
        end
        ST_INIT: begin
          init_ptr <= init_ptr_inc;
          if (init_last) begin
            free_head         <= '0;
            linked            <= init_n;
            used_bytes        <= '0;
            live_count        <= '0;
            rsp.status        <= STAT_OK;
            rsp.granted_index <= '0;
            rsp.used_total    <= '0;
            rsp.live_total    <= '0;
            done              <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/fixed_block_pool_allocator_core.sv
// top level of the block pool allocator: config registers, sequencer and link memory
// depends on fbpa_pkg, fbpa_ctrl, fbpa_link_ram
//
//   channel   handshake                          payload
//   request   start, transfer when !busy         req   (fbpa_req_t)
//   result    done strobe, one cycle             rsp   (fbpa_rsp_t)
//   config    apb, pready always high            paddr, pwdata, prdata
//
// free and unused codes: busy never rises, result on the next cycle
// allocate: passes through ST_ALLOC for the registered read of the link memory; straight from idle on an empty pool
// init: min(block_count, MAX_BLOCKS) link entries written in ST_INIT, one link entry written per cycle
// rst clears the head to the null mark and both counters; links stay unknown until init
// the receiver cannot stall, so a result never holds off the next request
`default_nettype none

module fixed_block_pool_allocator_core #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire fbpa_pkg::fbpa_req_t req,
  output logic                     busy,
  output logic                     done,
  output fbpa_pkg::fbpa_rsp_t      rsp,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import fbpa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);

  fbpa_cfg_t     cfg;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_count <= BLOCK_COUNT_RESET;
      cfg.object_size <= OBJECT_SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BLOCK_COUNT: cfg.block_count <= pwdata[8:0];
        REG_OBJECT_SIZE: cfg.object_size <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_COUNT: prdata = 32'(cfg.block_count);
      REG_OBJECT_SIZE: prdata = 32'(cfg.object_size);
      default:         prdata = '0;
    endcase
  end

  fbpa_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  fbpa_link_ram #(
    .DEPTH(MAX_BLOCKS),
    .DW   (LW)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

`default_nettype wire

### bench/tb_fixed_block_pool_allocator_core.sv
`timescale 1ns / 1ps
// self-checking bench for fixed_block_pool_allocator_core: a directed table, then random phases
// depends on fbpa_pkg and the allocator rtl; results checked against table rows or a pool model
module tb_fixed_block_pool_allocator_core;
  import fbpa_pkg::*;

  localparam int MAX_BLOCKS = 256;
  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam logic [8:0] NULL_MARK = 9'd256;
  localparam int TARGET_ITEMS = 1100;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam logic ROW_REQ = 1'b0;
  localparam logic ROW_CFG = 1'b1;
  localparam fbpa_rsp_t NO_RSP = '0;

  typedef struct packed {
    logic        kind;
    logic        reg_sel;
    logic [31:0] value;
    logic [1:0]  req_type;
    logic [7:0]  block_index;
    logic        typed;
    fbpa_rsp_t   rsp;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  fbpa_req_t   req;
  logic        busy;
  logic        done;
  fbpa_rsp_t   rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [8:0]  pool_link [MAX_BLOCKS];
  logic [8:0]  pool_head;
  logic [24:0] pool_used;
  logic [8:0]  pool_live;
  logic [8:0]  pool_linked;
  logic [8:0]  cfg_count;
  logic [16:0] cfg_size;

  fbpa_rsp_t rsp_due [$];
  fbpa_rsp_t due_rsp;
  int        held_blocks [$];
  int        mismatches;
  int        items_sent;
  int        idle_cycles;

  fixed_block_pool_allocator_core #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
    end
    mismatches++;
  endfunction

  // one request against the free list model, state updated in place
  function automatic fbpa_rsp_t pool_step(fbpa_req_t r);
    fbpa_rsp_t o;
    int        n;
    int        i;
    o = '0;
    case (r.req_type)
      REQ_INIT: begin
        n = (cfg_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_count);
        for (i = 0; i < n; i++) begin
          pool_link[i] = (i + 1 < n) ? 9'(i + 1) : NULL_MARK;
        end
        pool_head = (n > 0) ? 9'd0 : NULL_MARK;
        pool_linked = 9'(n);
        pool_used = '0;
        pool_live = '0;
      end
      REQ_ALLOC: begin
        if (pool_head < NULL_MARK) begin
          o.granted_index = pool_head[7:0];
          pool_head = pool_link[pool_head[7:0]];
          pool_used = pool_used + 25'(cfg_size);
          pool_live = pool_live + 9'd1;
        end else begin
          o.status = STAT_EMPTY;
        end
      end
      REQ_FREE: begin
        if (r.block_index >= pool_linked || pool_live == 9'd0) begin
          o.status = STAT_REJECTED;
        end else begin
          pool_link[r.block_index] = pool_head;
          pool_head = {1'b0, r.block_index};
          pool_used = pool_used - 25'(cfg_size);
          pool_live = pool_live - 9'd1;
        end
      end
      default: ;
    endcase
    o.used_total = pool_used;
    o.live_total = pool_live;
    return o;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic issue_request(fbpa_req_t r, int gap, logic typed, fbpa_rsp_t typed_rsp);
    fbpa_rsp_t predicted;
    int        j;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    req = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = pool_step(r);
    rsp_due.push_back(typed ? typed_rsp : predicted);
    items_sent++;
    if (r.req_type == REQ_INIT) begin
      held_blocks.delete();
    end else if (r.req_type == REQ_ALLOC && predicted.status == STAT_OK) begin
      held_blocks.push_back(int'(predicted.granted_index));
    end else if (r.req_type == REQ_FREE && predicted.status == STAT_OK) begin
      for (j = 0; j < held_blocks.size(); j++) begin
        if (held_blocks[j] == int'(r.block_index)) begin
          held_blocks.delete(j);
          break;
        end
      end
    end
    @(negedge clk);
  endtask

  // waits for the block to drain, writes one register, reads it back
  task automatic write_reg(logic reg_sel, logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] stored;
    start = 1'b0;
    while (rsp_due.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
    mask = (reg_sel == REG_OBJECT_SIZE) ? 32'h0001_FFFF : 32'h0000_01FF;
    if ($urandom_range(0, 1) == 1) begin
      value = (value & mask) | ($urandom & ~mask);
    end
    stored = value & mask;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_sel, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_OBJECT_SIZE) begin
      cfg_size = stored[16:0];
    end else begin
      cfg_count = stored[8:0];
    end
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored) note_mismatch("prdata", 64'(stored), 64'(prdata));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (rsp_due.size() == 0) begin
          note_mismatch("result with nothing due", 64'd0, 64'(rsp));
        end else begin
          due_rsp = rsp_due.pop_front();
          if (rsp.status !== due_rsp.status)
            note_mismatch("status", 64'(due_rsp.status), 64'(rsp.status));
          if (rsp.granted_index !== due_rsp.granted_index)
            note_mismatch("granted_index", 64'(due_rsp.granted_index), 64'(rsp.granted_index));
          if (rsp.used_total !== due_rsp.used_total)
            note_mismatch("used_total", 64'(due_rsp.used_total), 64'(rsp.used_total));
          if (rsp.live_total !== due_rsp.live_total)
            note_mismatch("live_total", 64'(due_rsp.live_total), 64'(rsp.live_total));
        end
      end
      if ((start && !busy) || done || (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("fixed_block_pool_allocator_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t  directed [31];
    fbpa_req_t r;
    int        phase_len;
    int        alloc_pct;
    int        pick;
    logic      no_gaps;
    logic [31:0] count_val;
    logic [31:0] size_val;

    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (pool_link[k]) pool_link[k] = '0;
    pool_head = NULL_MARK;
    pool_used = '0;
    pool_live = '0;
    pool_linked = '0;
    cfg_count = BLOCK_COUNT_RESET;
    cfg_size = OBJECT_SIZE_RESET;
    mismatches = 0;
    items_sent = 0;
    idle_cycles = 0;

    directed = '{
      // before any init: empty pool, rejected free, unused code; then init and two allocs
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b1, '{STAT_EMPTY, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd0,   1'b1, '{STAT_REJECTED, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_NOP,   8'd255, 1'b1, '{STAT_OK, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_INIT,  8'd0,   1'b1, '{STAT_OK, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b1, '{STAT_OK, 8'd0, 25'd16, 9'd1}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b1, '{STAT_OK, 8'd1, 25'd32, 9'd2}},
      // double free of a block never granted, then free with nothing live
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd255, 1'b1, '{STAT_OK, 8'd0, 25'd16, 9'd1}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd255, 1'b1, '{STAT_OK, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd0,   1'b1, '{STAT_REJECTED, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b0, NO_RSP},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b0, NO_RSP},
      '{ROW_REQ, 1'b0, 32'd0, REQ_NOP,   8'd0,   1'b0, NO_RSP},
      // single block pool
      '{ROW_CFG, REG_BLOCK_COUNT, 32'd1,     REQ_NOP, 8'd0, 1'b0, NO_RSP},
      '{ROW_CFG, REG_OBJECT_SIZE, 32'd65536, REQ_NOP, 8'd0, 1'b0, NO_RSP},
      '{ROW_REQ, 1'b0, 32'd0, REQ_INIT,  8'd0,   1'b1, '{STAT_OK, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b1, '{STAT_OK, 8'd0, 25'd65536, 9'd1}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b1, '{STAT_EMPTY, 8'd0, 25'd65536, 9'd1}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd1,   1'b1, '{STAT_REJECTED, 8'd0, 25'd65536, 9'd1}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd0,   1'b1, '{STAT_OK, 8'd0, 25'd0, 9'd0}},
      // zero blocks
      '{ROW_CFG, REG_BLOCK_COUNT, 32'd0, REQ_NOP, 8'd0, 1'b0, NO_RSP},
      '{ROW_CFG, REG_OBJECT_SIZE, 32'd8, REQ_NOP, 8'd0, 1'b0, NO_RSP},
      '{ROW_REQ, 1'b0, 32'd0, REQ_INIT,  8'd0,   1'b1, '{STAT_OK, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b1, '{STAT_EMPTY, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd0,   1'b1, '{STAT_REJECTED, 8'd0, 25'd0, 9'd0}},
      // count above the pool size, largest object size
      '{ROW_CFG, REG_BLOCK_COUNT, 32'd511,    REQ_NOP, 8'd0, 1'b0, NO_RSP},
      '{ROW_CFG, REG_OBJECT_SIZE, 32'd131071, REQ_NOP, 8'd0, 1'b0, NO_RSP},
      '{ROW_REQ, 1'b0, 32'd0, REQ_INIT,  8'd0,   1'b1, '{STAT_OK, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b1, '{STAT_OK, 8'd0, 25'd131071, 9'd1}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd255, 1'b1, '{STAT_OK, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_FREE,  8'd255, 1'b1, '{STAT_REJECTED, 8'd0, 25'd0, 9'd0}},
      '{ROW_REQ, 1'b0, 32'd0, REQ_ALLOC, 8'd0,   1'b0, NO_RSP}
    };

    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CFG) begin
        write_reg(directed[k].reg_sel, directed[k].value);
      end else begin
        r.req_type = directed[k].req_type;
        r.block_index = directed[k].block_index;
        issue_request(r, $urandom_range(0, 4), directed[k].typed, directed[k].rsp);
      end
    end

    // double free of the head makes the list loop on itself, so allocs never run dry
    // and both counters wrap
    write_reg(REG_BLOCK_COUNT, $urandom_range(2, 256));
    write_reg(REG_OBJECT_SIZE, $urandom_range(131000, 131071));
    r = '{REQ_INIT, 8'd0};
    issue_request(r, $urandom_range(0, 4), 1'b0, NO_RSP);
    r = '{REQ_ALLOC, 8'($urandom_range(0, 255))};
    issue_request(r, $urandom_range(0, 4), 1'b0, NO_RSP);
    issue_request(r, $urandom_range(0, 4), 1'b0, NO_RSP);
    r = '{REQ_FREE, 8'd0};
    issue_request(r, $urandom_range(0, 4), 1'b0, NO_RSP);
    issue_request(r, $urandom_range(0, 4), 1'b0, NO_RSP);
    repeat (640) begin
      r.req_type = ($urandom_range(0, 9) == 0) ? REQ_NOP : REQ_ALLOC;
      r.block_index = 8'($urandom_range(0, 255));
      issue_request(r, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4), 1'b0, NO_RSP);
    end

    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 6);
      case (pick)
        0: count_val = 32'd0;
        1: count_val = 32'd1;
        2: count_val = 32'd2;
        3: count_val = 32'd256;
        4: count_val = 32'd511;
        5: count_val = $urandom_range(3, 255);
        default: count_val = $urandom_range(0, 511);
      endcase
      pick = $urandom_range(0, 5);
      case (pick)
        0: size_val = 32'd8;
        1: size_val = 32'd65536;
        2: size_val = 32'd131071;
        3: size_val = 32'd16;
        default: size_val = $urandom_range(0, 131071);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_BLOCK_COUNT, count_val);
        write_reg(REG_OBJECT_SIZE, size_val);
      end else begin
        write_reg(REG_OBJECT_SIZE, size_val);
        write_reg(REG_BLOCK_COUNT, count_val);
      end
      phase_len = $urandom_range(20, 80);
      alloc_pct = $urandom_range(25, 70);
      no_gaps = ($urandom_range(0, 3) == 0);
      // some phases keep the old list so a new object size meets blocks still out
      if ($urandom_range(0, 3) != 0) begin
        r = '{REQ_INIT, 8'($urandom_range(0, 255))};
        issue_request(r, no_gaps ? 0 : $urandom_range(0, 4), 1'b0, NO_RSP);
      end
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        r.block_index = 8'($urandom_range(0, 255));
        if (pick < alloc_pct) begin
          r.req_type = REQ_ALLOC;
        end else if (pick < 93) begin
          r.req_type = REQ_FREE;
          if (held_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
            r.block_index = 8'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
          end
        end else if (pick < 96) begin
          r.req_type = REQ_INIT;
        end else begin
          r.req_type = REQ_NOP;
        end
        issue_request(r, no_gaps ? 0 : $urandom_range(0, 4), 1'b0, NO_RSP);
      end
    end

    start = 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("fixed_block_pool_allocator_core: match");
    end else begin
      $display("fixed_block_pool_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
